### design/nearest_point_touch_select_core_assert.svh
// Assertion macros shared by the block. Each expects clk and arst_n in scope.
`ifndef NEAREST_POINT_TOUCH_SELECT_CORE_ASSERT_SVH
`define NEAREST_POINT_TOUCH_SELECT_CORE_ASSERT_SVH

// Same-cycle implication.
`define NPTS_ASSERT_IMPL(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define NPTS_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### design/npts_pkg.sv
`default_nettype none

package npts_pkg;

	localparam int COORD_W = 12;
	localparam int IDX_W = 8;
	localparam int COUNT_W = 9;
	localparam int SCORE_W = 11;
	localparam int MAX_ENTRIES_DEF = 256;

	localparam logic [SCORE_W-1:0] SCORE_LIMIT = 11'(36 * 36);

	// Label box, relative to the marker position.
	localparam int LABEL_LEFT = 10;
	localparam int LABEL_RIGHT = 132;
	localparam int LABEL_UP = 26;
	localparam int LABEL_DOWN = 46;
	localparam int LABEL_DIV_SH = 3;
	localparam int LABEL_CX = (LABEL_LEFT + LABEL_RIGHT) / 2;
	localparam int LABEL_CY = (LABEL_DOWN - LABEL_UP) / 2;

	typedef enum logic {
		FUNC_STORE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef struct packed {
		func_t                     func;
		logic [IDX_W-1:0]          entry_index;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [COUNT_W-1:0]        live_count;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   best_index;
		logic [SCORE_W-1:0] best_score;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	// Control that travels alongside an entry through the scoring pipeline.
	typedef struct packed {
		logic act;
		logic ok;
		logic last;
	} tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### design/nearest_point_touch_select_core.sv
// Nearest marker selection for touch input.
// Input channel in_valid/in_ready/in_req carries store and query requests;
// output channel out_valid/out_ready/out_rsp carries one result per query.
// A store writes one marker into a ring of MAX_ENTRIES cells and gives no
// result. A query rotates the whole ring once, one entry per cycle into a
// three-stage scoring pipeline; after the scan the pipeline drains and the
// result is loaded into the result register. The next request can be taken
// in the cycle after the result is registered; stores run at one per cycle
// while no query is in progress.
// The result register holds the last selection. If the receiver stalls, new
// stores and a new query are still taken; a finished query then waits until
// the pending result has been taken.
// Reset clears the control state and the result register; the marker table is
// undefined until written and needs no clearing pass.
`default_nettype none
`include "nearest_point_touch_select_core_assert.svh"

module nearest_point_touch_select_core #(
	parameter int MAX_ENTRIES = npts_pkg::MAX_ENTRIES_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  npts_pkg::req_t   in_req,
	output logic             out_valid,
	input  logic             out_ready,
	output npts_pkg::rsp_t   out_rsp
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = (CW > npts_pkg::COUNT_W) ? CW : npts_pkg::COUNT_W;
	localparam logic [CW-1:0] LAST_CNT = CW'(MAX_ENTRIES - 1);
	localparam logic [LW-1:0] MAX_L = LW'(MAX_ENTRIES);

	npts_pkg::state_t state_q, state_d;
	logic             shift_en, load_out;
	logic             in_fire, store_fire, query_fire;

	logic [CW-1:0]    cnt_q, lim_q;
	logic [LW-1:0]    live_l;
	npts_pkg::point_t touch_q, req_pt;

	logic [npts_pkg::SCORE_W-1:0] best_q, score_s3;
	logic [IW-1:0]                bidx_q, idx_s3;
	logic                         hit_q;
	npts_pkg::tag_t               tag_in, tag_s3;

	logic           out_valid_q;
	npts_pkg::rsp_t out_rsp_q;

	assign in_fire = in_valid && in_ready;
	assign store_fire = in_fire && (in_req.func == npts_pkg::FUNC_STORE);
	assign query_fire = in_fire && (in_req.func == npts_pkg::FUNC_QUERY);
	assign req_pt.x = in_req.pos_x;
	assign req_pt.y = in_req.pos_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		shift_en = 1'b0;
		load_out = 1'b0;
		case (state_q)
			npts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (in_req.func == npts_pkg::FUNC_QUERY)) begin
					state_d = npts_pkg::ST_SCAN;
				end
			end
			npts_pkg::ST_SCAN: begin
				shift_en = 1'b1;
				if (cnt_q == LAST_CNT) begin
					state_d = npts_pkg::ST_DRAIN;
				end
			end
			npts_pkg::ST_DRAIN: begin
				if (tag_s3.act && tag_s3.last) begin
					state_d = npts_pkg::ST_DONE;
				end
			end
			npts_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = npts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = npts_pkg::ST_IDLE;
			end
		endcase
	end

	// Scan position; after a full turn the ring is back in index order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (query_fire) begin
			cnt_q <= '0;
		end else if (shift_en) begin
			cnt_q <= (cnt_q == LAST_CNT) ? '0 : cnt_q + 1'b1;
		end
	end

	assign live_l = LW'(in_req.live_count);

	always_ff @(posedge clk) begin
		if (query_fire) begin
			lim_q <= (live_l > MAX_L) ? CW'(MAX_ENTRIES) : live_l[CW-1:0];
			touch_q <= req_pt;
		end
	end

	// Ring of marker cells; cell 0 is the head that feeds the scorer.
	npts_pkg::point_t       cell_pt [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] cell_load;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		assign cell_load[i] = store_fire && (32'(in_req.entry_index) == i);

		npts_cell u_cell (
			.clk     (clk),
			.load    (cell_load[i]),
			.shift   (shift_en),
			.load_pt (req_pt),
			.next_pt (cell_pt[(i + 1) % MAX_ENTRIES]),
			.pt      (cell_pt[i])
		);
	end

	assign tag_in.act = shift_en;
	assign tag_in.ok = cnt_q < lim_q;
	assign tag_in.last = cnt_q == LAST_CNT;

	npts_score #(
		.IW (IW)
	) u_score (
		.clk     (clk),
		.arst_n  (arst_n),
		.ent     (cell_pt[0]),
		.touch   (touch_q),
		.tag_in  (tag_in),
		.idx_in  (cnt_q[IW-1:0]),
		.tag_out (tag_s3),
		.idx_out (idx_s3),
		.score   (score_s3)
	);

	// Strict compare keeps the first entry on a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= npts_pkg::SCORE_LIMIT;
			bidx_q <= '0;
			hit_q <= 1'b0;
		end else if (query_fire) begin
			best_q <= npts_pkg::SCORE_LIMIT;
			bidx_q <= '0;
			hit_q <= 1'b0;
		end else if (tag_s3.act && tag_s3.ok && (score_s3 < best_q)) begin
			best_q <= score_s3;
			bidx_q <= idx_s3;
			hit_q <= 1'b1;
		end
	end

	// The result register holds the selection of the last finished query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_rsp_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_rsp_q.hit <= hit_q;
				out_rsp_q.best_index <= npts_pkg::IDX_W'(bidx_q);
				out_rsp_q.best_score <= best_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp = out_rsp_q;

	`NPTS_ASSERT_IMPL(a_no_store_during_scan, shift_en, cell_load == '0, "store during scan")
	`NPTS_ASSERT_IMPL(a_hit_below_limit, hit_q, best_q < npts_pkg::SCORE_LIMIT, "hit at limit")
	`NPTS_ASSERT_IMPL(a_miss_defaults, out_valid && !out_rsp.hit, (out_rsp.best_index == '0) && (out_rsp.best_score == npts_pkg::SCORE_LIMIT), "miss fields wrong")
	`NPTS_ASSERT_NEXT(a_result_shown, load_out, out_valid, "result not presented")

endmodule

`default_nettype wire

### design/npts_cell.sv
`default_nettype none

module npts_cell (
	input  wire                 clk,
	input  logic                load,
	input  logic                shift,
	input  npts_pkg::point_t    load_pt,
	input  npts_pkg::point_t    next_pt,
	output npts_pkg::point_t    pt
);

	npts_pkg::point_t pt_q;

	// A store writes the cell directly; during a scan it takes its neighbor's entry.
	always_ff @(posedge clk) begin
		if (load) begin
			pt_q <= load_pt;
		end else if (shift) begin
			pt_q <= next_pt;
		end
	end

	assign pt = pt_q;

endmodule

`default_nettype wire

### design/npts_score.sv
`default_nettype none

module npts_score #(
	parameter int IW = 8
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  npts_pkg::point_t                   ent,
	input  npts_pkg::point_t                   touch,
	input  npts_pkg::tag_t                     tag_in,
	input  logic [IW-1:0]                      idx_in,
	output npts_pkg::tag_t                     tag_out,
	output logic [IW-1:0]                      idx_out,
	output logic [npts_pkg::SCORE_W-1:0]       score
);

	localparam logic signed [12:0] BOX_L = 13'(npts_pkg::LABEL_LEFT);
	localparam logic signed [12:0] BOX_R = 13'(npts_pkg::LABEL_RIGHT);
	localparam logic signed [12:0] BOX_T = 13'(-npts_pkg::LABEL_UP);
	localparam logic signed [12:0] BOX_B = 13'(npts_pkg::LABEL_DOWN);
	localparam logic signed [12:0] CEN_X = 13'(npts_pkg::LABEL_CX);
	localparam logic signed [12:0] CEN_Y = 13'(npts_pkg::LABEL_CY);

	// Stage 1: offsets of the touch point from the marker.
	logic signed [12:0] rx, ry, lxf, lyf;
	logic               inbox;

	assign rx = $signed({touch.x[11], touch.x}) - $signed({ent.x[11], ent.x});
	assign ry = $signed({touch.y[11], touch.y}) - $signed({ent.y[11], ent.y});
	assign lxf = rx - CEN_X;
	assign lyf = ry - CEN_Y;
	assign inbox = (rx >= BOX_L) && (rx <= BOX_R) && (ry >= BOX_T) && (ry <= BOX_B);

	logic signed [12:0] rx_s1, ry_s1;
	logic signed [7:0]  lx_s1;
	logic signed [6:0]  ly_s1;
	logic               inbox_s1;
	logic [IW-1:0]      idx_s1;
	npts_pkg::tag_t     tag_s1;

	// Inside the box the centre offsets are small, so narrow copies suffice.
	always_ff @(posedge clk) begin
		rx_s1 <= rx;
		ry_s1 <= ry;
		lx_s1 <= lxf[7:0];
		ly_s1 <= lyf[6:0];
		inbox_s1 <= inbox;
		idx_s1 <= idx_in;
	end

	// Stage 2: squares.
	logic signed [25:0] rxx, ryy;
	logic signed [15:0] lxx;
	logic signed [13:0] lyy;

	assign rxx = rx_s1 * rx_s1;
	assign ryy = ry_s1 * ry_s1;
	assign lxx = lx_s1 * lx_s1;
	assign lyy = ly_s1 * ly_s1;

	logic [23:0]    dx2_s2, dy2_s2;
	logic [12:0]    lq_s2;
	logic           inbox_s2;
	logic [IW-1:0]  idx_s2;
	npts_pkg::tag_t tag_s2;

	always_ff @(posedge clk) begin
		dx2_s2 <= rxx[23:0];
		dy2_s2 <= ryy[23:0];
		lq_s2 <= 13'(lxx) + 13'(lyy);
		inbox_s2 <= inbox_s1;
		idx_s2 <= idx_s1;
	end

	// Stage 3: distance, label reduction and clamp to the limit.
	logic [24:0] dsq, alt, sc;

	assign dsq = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign alt = 25'(lq_s2 >> npts_pkg::LABEL_DIV_SH);
	assign sc = (inbox_s2 && (alt < dsq)) ? alt : dsq;

	logic [npts_pkg::SCORE_W-1:0] score_s3;
	logic [IW-1:0]                idx_s3;
	npts_pkg::tag_t               tag_s3;

	always_ff @(posedge clk) begin
		score_s3 <= (sc >= 25'(npts_pkg::SCORE_LIMIT)) ? npts_pkg::SCORE_LIMIT
			: sc[npts_pkg::SCORE_W-1:0];
		idx_s3 <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign tag_out = tag_s3;
	assign idx_out = idx_s3;
	assign score = score_s3;

endmodule

`default_nettype wire
